[design/usd_pkg.sv]
// Shared types, constants and widths for the UTF-8 stream decoder.
`default_nettype none
package usd_pkg;

   localparam int ByteWidth   = 8;
   localparam int CpWidth     = 22;
   localparam int LeftWidth   = 2;
   localparam int PayloadBits = 6;
   localparam int RspDataWidth = ((CpWidth + 7) / 8) * 8;

   // Lead byte tag patterns and payload masks
   localparam logic [ByteWidth-1:0] TopBit     = 8'b1000_0000;
   localparam logic [ByteWidth-1:0] Lead4Tag   = 8'b1111_0000;
   localparam logic [ByteWidth-1:0] Lead4Mask  = 8'b0000_1111;
   localparam logic [ByteWidth-1:0] Lead3Tag   = 8'b1110_0000;
   localparam logic [ByteWidth-1:0] Lead3Mask  = 8'b0001_1111;
   localparam logic [ByteWidth-1:0] Lead2Tag   = 8'b1100_0000;
   localparam logic [ByteWidth-1:0] Lead2Mask  = 8'b0011_1111;

   // Code point reported for a continuation byte in lead position
   localparam logic [CpWidth-1:0] BadLeadCp = 22'd1;

   // Continuation counts
   localparam logic [LeftWidth-1:0] LeftNone  = 2'd0;
   localparam logic [LeftWidth-1:0] LeftOne   = 2'd1;
   localparam logic [LeftWidth-1:0] LeftTwo   = 2'd2;
   localparam logic [LeftWidth-1:0] LeftThree = 2'd3;

   // Decoder state carried between items
   typedef struct packed {
      logic [LeftWidth-1:0] bytes_left;
      logic [CpWidth-1:0]   accumulator;
   } state_type;

   // Result produced by one decode step
   typedef struct packed {
      logic               emit;
      logic [CpWidth-1:0] code_point;
      logic               bad_lead;
   } result_type;

endpackage
`default_nettype wire

[design/usd_decode.sv]
// Single-step UTF-8 decode: next state and optional result for one byte.
`default_nettype none
module usd_decode (
   input  wire logic [usd_pkg::ByteWidth-1:0] byte_in,
   input  wire usd_pkg::state_type            state_cur,
   output usd_pkg::state_type                 state_nxt,
   output usd_pkg::result_type                result
);

   logic [usd_pkg::CpWidth-1:0] cont_bits;
   logic [usd_pkg::CpWidth-1:0] merged;

   // Continuation payload placed at the shift set by the remaining count
   always_comb begin
      cont_bits = '0;
      unique case (state_cur.bytes_left)
         usd_pkg::LeftThree: cont_bits = {4'b0, byte_in[5:0], 12'b0};
         usd_pkg::LeftTwo:   cont_bits = {10'b0, byte_in[5:0], 6'b0};
         usd_pkg::LeftOne:   cont_bits = {16'b0, byte_in[5:0]};
         default:            cont_bits = '0;
      endcase
   end

   assign merged = state_cur.accumulator | cont_bits;

   // Lead or continuation handling
   always_comb begin
      state_nxt         = state_cur;
      result.emit       = 1'b0;
      result.code_point = merged;
      result.bad_lead   = 1'b0;
      priority if (state_cur.bytes_left != usd_pkg::LeftNone) begin
         state_nxt.accumulator = merged;
         state_nxt.bytes_left  = state_cur.bytes_left - usd_pkg::LeftOne;
         result.emit           = (state_cur.bytes_left == usd_pkg::LeftOne);
      end else if ((byte_in & usd_pkg::TopBit) == '0) begin
         result.emit       = 1'b1;
         result.code_point = {14'b0, byte_in};
      end else if ((byte_in & usd_pkg::Lead4Tag) == usd_pkg::Lead4Tag) begin
         state_nxt.bytes_left  = usd_pkg::LeftThree;
         state_nxt.accumulator = {byte_in[3:0], 18'b0};
      end else if ((byte_in & usd_pkg::Lead3Tag) == usd_pkg::Lead3Tag) begin
         state_nxt.bytes_left  = usd_pkg::LeftTwo;
         state_nxt.accumulator = {5'b0, byte_in[4:0], 12'b0};
      end else if ((byte_in & usd_pkg::Lead2Tag) == usd_pkg::Lead2Tag) begin
         state_nxt.bytes_left  = usd_pkg::LeftOne;
         state_nxt.accumulator = {10'b0, byte_in[5:0], 6'b0};
      end else begin
         result.emit       = 1'b1;
         result.code_point = usd_pkg::BadLeadCp;
         result.bad_lead   = 1'b1;
      end
   end

endmodule
`default_nettype wire

[design/usd_out_stage.sv]
// Result register: holds one decoded item until the receiver takes it.
`default_nettype none
module usd_out_stage (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              load,
   input  wire usd_pkg::result_type               result,
   output logic                                   space,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [usd_pkg::RspDataWidth-1:0]       rsp_tdata,
   output logic                                   rsp_tuser
);

   logic                        valid_ff, valid_in;
   logic [usd_pkg::CpWidth-1:0] cp_ff;
   logic                        bad_ff;

   // Room for a new item when empty or when the held item leaves now
   assign space    = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         cp_ff  <= result.code_point;
         bad_ff <= result.bad_lead;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(usd_pkg::RspDataWidth - usd_pkg::CpWidth){1'b0}}, cp_ff};
   assign rsp_tuser  = bad_ff;

endmodule
`default_nettype wire

[design/utf8_stream_decoder.sv]
// Top level of the byte-serial UTF-8 stream decoder.
// Usage:
//   req_* channel carries one raw byte per item in req_tdata[7:0].
//   rsp_* channel carries one decoded code point per item in rsp_tdata[21:0]
//   and the bad-lead flag in rsp_tuser.
//   An ASCII byte, a stray continuation byte in lead position, or the last
//   byte of a multi-byte sequence each yield one result item; lead bytes and
//   inner continuation bytes yield none.
// Path: an accepted byte is held in the input register, decoded out of it, and
//   lands in the result register once the result register has space.
// Throughput: one byte per cycle while the result register has space, set by
//   the combinational decode between the input register and the result
//   register; the decoder state updates as each byte leaves the input register.
// Stall: when rsp_tready is low with a result held, the input register keeps
//   its byte and req_tready drops once it is full; nothing is lost.
// Reset: synchronous, active high; clears both registers' valid flags and
//   the decoder state, so the next byte is taken as a lead byte.
`default_nettype none
module utf8_stream_decoder (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [7:0]                  req_tdata,   // [7:0] byte_in
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [usd_pkg::RspDataWidth-1:0] rsp_tdata,   // [21:0] code_point, zero fill
   output logic                             rsp_tuser    // [0] bad_lead
);

   logic                          in_valid_ff, in_valid_in;
   logic [usd_pkg::ByteWidth-1:0] in_byte_ff;
   usd_pkg::state_type            state_ff, state_in;
   usd_pkg::state_type            state_nxt;
   usd_pkg::result_type           result;
   logic                          space;
   logic                          advance;
   logic                          req_take;

   // Pipeline control
   assign advance     = in_valid_ff && space;
   assign req_tready  = !in_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign state_in    = advance ? state_nxt : state_ff;

   // Input register and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   // Byte payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
      end
   end

   usd_decode u_decode (
      .byte_in   (in_byte_ff),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .result    (result)
   );

   usd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && result.emit),
      .result     (result),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTH
   // A bad lead always reports code point one
   a_bad_lead_cp: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[21:0] == usd_pkg::BadLeadCp))
      else $error("bad lead result without code point one");

   // An emitting decode step shows up as a valid result next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (advance && result.emit) |=> rsp_tvalid)
      else $error("emitted item not presented");

   // Bits still to be filled by pending continuations are clear
   a_acc_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff.bytes_left == usd_pkg::LeftOne) |-> (state_ff.accumulator[5:0] == '0))
      else $error("accumulator low bits set with one continuation left");

   a_acc_two: assert property (@(posedge clock) disable iff (reset)
      (state_ff.bytes_left == usd_pkg::LeftTwo) |-> (state_ff.accumulator[11:0] == '0))
      else $error("accumulator low bits set with two continuations left");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the UTF-8 stream decoder: stimulus, prediction, checks.
`timescale 1ns / 100ps
module tb_top;

   localparam int RandomItems = 1400;
   localparam logic [usd_pkg::ByteWidth-1:0] ContMask = 8'b0011_1111;

   typedef logic [usd_pkg::CpWidth-1:0]      cp_type;
   typedef logic [usd_pkg::RspDataWidth-1:0] rsp_data_type;

   // One decoded character as seen on the result channel
   typedef struct packed {
      logic [usd_pkg::CpWidth-1:0] code_point;
      logic                        bad_lead;
   } decoded_char_type;

   // Tracks the decoder state and holds the characters still to come out
   class utf8_scoreboard;
      logic [usd_pkg::LeftWidth-1:0] bytes_left;
      logic [usd_pkg::CpWidth-1:0]   accumulator;
      decoded_char_type              char_q[$];
      int unsigned                   error_count;
      int unsigned                   rsp_count;

      function new();
         bytes_left  = usd_pkg::LeftNone;
         accumulator = '0;
         error_count = 0;
         rsp_count   = 0;
      endfunction

      function int unsigned pending();
         return char_q.size();
      endfunction

      // Advance the decoder state by one accepted byte
      function void note_byte(logic [usd_pkg::ByteWidth-1:0] b);
         decoded_char_type c;
         int unsigned      shamt;
         if (bytes_left != usd_pkg::LeftNone) begin
            // continuation: tag bits ignored, payload at its slot
            shamt       = (int'(bytes_left) - 1) * usd_pkg::PayloadBits;
            accumulator = accumulator | (cp_type'(b & ContMask) << shamt);
            bytes_left  = bytes_left - 1'b1;
            if (bytes_left == usd_pkg::LeftNone) begin
               c.code_point = accumulator;
               c.bad_lead   = 1'b0;
               char_q.push_back(c);
            end
         end else if ((b & usd_pkg::TopBit) == '0) begin
            c.code_point = cp_type'(b);
            c.bad_lead   = 1'b0;
            char_q.push_back(c);
         end else if ((b & usd_pkg::Lead4Tag) == usd_pkg::Lead4Tag) begin
            bytes_left  = usd_pkg::LeftThree;
            accumulator = cp_type'(b & usd_pkg::Lead4Mask) << (3 * usd_pkg::PayloadBits);
         end else if ((b & usd_pkg::Lead3Tag) == usd_pkg::Lead3Tag) begin
            bytes_left  = usd_pkg::LeftTwo;
            accumulator = cp_type'(b & usd_pkg::Lead3Mask) << (2 * usd_pkg::PayloadBits);
         end else if ((b & usd_pkg::Lead2Tag) == usd_pkg::Lead2Tag) begin
            bytes_left  = usd_pkg::LeftOne;
            accumulator = cp_type'(b & usd_pkg::Lead2Mask) << usd_pkg::PayloadBits;
         end else begin
            // stray continuation in lead position
            c.code_point = usd_pkg::BadLeadCp;
            c.bad_lead   = 1'b1;
            char_q.push_back(c);
         end
      endfunction

      task report(input string msg);
         $display("mismatch @%0t: %s", $realtime, msg);
         error_count++;
      endtask

      // Compare one accepted result with the oldest expected character
      task check_result(input logic [usd_pkg::RspDataWidth-1:0] data, input logic flag);
         decoded_char_type c;
         rsp_count++;
         if (char_q.size() == 0) begin
            report($sformatf("result %0d unexpected: cp=%h bad=%b", rsp_count, data, flag));
         end else begin
            c = char_q.pop_front();
            if (data !== rsp_data_type'(c.code_point))
               report($sformatf("result %0d code point %h, want %h",
                                rsp_count, data, c.code_point));
            if (flag !== c.bad_lead)
               report($sformatf("result %0d bad_lead %b, want %b",
                                rsp_count, flag, c.bad_lead));
         end
      endtask
   endclass

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [usd_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                             rsp_tuser;

   utf8_scoreboard decoder_sb = new();

   utf8_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop in case the decoder hangs
   initial begin
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

   // Receiver: stall pattern switches between modes every so often
   logic [1:0] stall_mode = 2'd0;
   int         mode_left  = 0;
   logic [4:0] stall_phase = '0;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         decoder_sb.check_result(rsp_tdata, rsp_tuser);
      stall_phase <= stall_phase + 1'b1;
      if (mode_left == 0) begin
         stall_mode <= 2'($urandom_range(0, 3));
         mode_left  <= $urandom_range(20, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));
         2'd2: rsp_tready <= (stall_phase[1:0] == 2'd0);
         default: rsp_tready <= (stall_phase == 5'd31);
      endcase
   end

   // Sender side
   int burst_left = 0;

   task automatic send_byte(input logic [7:0] value);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decoder_sb.note_byte(value);
   endtask

   // Bursts of random length separated by random gaps
   task automatic feed_byte(input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      send_byte(value);
      burst_left--;
   endtask

   function automatic logic [7:0] cont_byte();
      return {2'b10, 6'($urandom)};
   endfunction

   // Edge values, every lead kind, unchecked continuation tags, 11111xxx leads
   logic [7:0] directed_bytes [0:25] = '{
      8'h00, 8'h7F,
      8'h80, 8'hBF,
      8'hC0, 8'h80,
      8'hDF, 8'hBF,
      8'hE0, 8'h80, 8'h80,
      8'hEF, 8'hFF, 8'hFF,
      8'hF0, 8'h80, 8'h80, 8'h80,
      8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hF8, 8'h00, 8'h7F, 8'hC0
   };

   initial begin
      int fed;
      int kind;
      int conts;
      bit drained;
      fed     = 0;
      drained = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i]) feed_byte(directed_bytes[i]);

      // Mostly well-formed sequences with random payload, some noise
      while (fed < RandomItems) begin
         if (!drained && fed >= RandomItems / 2) begin
            // hold off until every pending character has come out
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (decoder_sb.pending() != 0) @(posedge clock);
            drained = 1;
         end
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2: begin
               feed_byte({1'b0, 7'($urandom)});
               fed += 1;
            end
            3, 4: begin
               feed_byte({3'b110, 5'($urandom)});
               feed_byte(cont_byte());
               fed += 2;
            end
            5: begin
               feed_byte({4'b1110, 4'($urandom)});
               repeat (2) feed_byte(cont_byte());
               fed += 3;
            end
            6: begin
               feed_byte({4'b1111, 4'($urandom)});
               repeat (3) feed_byte(cont_byte());
               fed += 4;
            end
            7: begin
               feed_byte(cont_byte());
               fed += 1;
            end
            8: begin
               feed_byte(8'($urandom));
               fed += 1;
            end
            default: begin
               // lead followed by arbitrary bytes in continuation slots
               conts = $urandom_range(1, 3);
               case (conts)
                  1: feed_byte({3'b110, 5'($urandom)});
                  2: feed_byte({4'b1110, 4'($urandom)});
                  default: feed_byte({4'b1111, 4'($urandom)});
               endcase
               repeat (conts) feed_byte(8'($urandom));
               fed += conts + 1;
            end
         endcase
      end
      req_tvalid <= 1'b0;

      // Drain, then give the pipeline more time before the final check
      for (int n = 0; n < 20000 && decoder_sb.pending() != 0; n++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (decoder_sb.pending() != 0)
         decoder_sb.report($sformatf("%0d characters never came out", decoder_sb.pending()));
      if (decoder_sb.error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[utf8_stream_decoder.f]
design/usd_pkg.sv
design/usd_decode.sv
design/usd_out_stage.sv
design/utf8_stream_decoder.sv
tb/tb_top.sv
